// ===== hdl/gimli_pkg.sv =====
// ----------------------------------------------------------------------------
// gimli_pkg: shared types and constants
// Holds the state type of the permutation and the fixed round constants.
// ----------------------------------------------------------------------------
package gimli_pkg;

  localparam int unsigned NWORDS = 12;
  localparam int unsigned NCOLS  = 4;

  localparam int unsigned ROT_X = 24;
  localparam int unsigned ROT_Y = 9;

  localparam logic [31:0] RC_BASE = 32'h9e377900;

  // round number modulo four selects the row-0 swap
  localparam logic [1:0] PHASE_SMALL = 2'd0;
  localparam logic [1:0] PHASE_BIG   = 2'd2;

  typedef logic [31:0] word_t;
  typedef logic [NWORDS-1:0][31:0] state_t;

endpackage

// ===== hdl/gimli_round.sv =====
// ----------------------------------------------------------------------------
// gimli_round: one round cell of the permutation chain
// Applies the column SP-boxes, the swap and constant of its round number, and
// registers the state with its valid bit when the chain advances.
// ----------------------------------------------------------------------------
module gimli_round #(
  parameter int unsigned ROUND_NUM = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              prev_valid,
  input  gimli_pkg::state_t prev_state,
  output logic              valid,
  output gimli_pkg::state_t state
);

  localparam logic [1:0]  PHASE = ROUND_NUM[1:0];
  localparam logic [31:0] RC    = gimli_pkg::RC_BASE ^ 32'(ROUND_NUM);

  logic [gimli_pkg::NCOLS-1:0][31:0] xr;
  logic [gimli_pkg::NCOLS-1:0][31:0] yr;
  logic [gimli_pkg::NCOLS-1:0][31:0] zr;
  gimli_pkg::state_t                 mixed;
  gimli_pkg::state_t                 state_next;

  // SP-box on every column
  always_comb begin
    mixed = prev_state;
    for (int c = 0; c < int'(gimli_pkg::NCOLS); c++) begin
      xr[c] = (prev_state[c] << gimli_pkg::ROT_X) |
              (prev_state[c] >> (32 - gimli_pkg::ROT_X));
      yr[c] = (prev_state[gimli_pkg::NCOLS + c] << gimli_pkg::ROT_Y) |
              (prev_state[gimli_pkg::NCOLS + c] >> (32 - gimli_pkg::ROT_Y));
      zr[c] = prev_state[2 * gimli_pkg::NCOLS + c];
      mixed[2 * gimli_pkg::NCOLS + c] = xr[c] ^ (zr[c] << 1) ^ ((yr[c] & zr[c]) << 2);
      mixed[gimli_pkg::NCOLS + c]     = yr[c] ^ xr[c] ^ ((xr[c] | zr[c]) << 1);
      mixed[c]                        = zr[c] ^ yr[c] ^ ((xr[c] & yr[c]) << 3);
    end
  end

  // row-0 swap and round constant
  always_comb begin
    state_next = mixed;
    case (PHASE)
      gimli_pkg::PHASE_SMALL: begin
        state_next[0] = mixed[1] ^ RC;
        state_next[1] = mixed[0];
        state_next[2] = mixed[3];
        state_next[3] = mixed[2];
      end
      gimli_pkg::PHASE_BIG: begin
        state_next[0] = mixed[2];
        state_next[1] = mixed[3];
        state_next[2] = mixed[0];
        state_next[3] = mixed[1];
      end
      default: begin
        state_next = mixed;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      state <= state_next;
    end
  end

endmodule

// ===== hdl/gimli_permutation.sv =====
// ----------------------------------------------------------------------------
// gimli_permutation: pipelined Gimli-384 permutation
// A chain of one cell per round; takes a new state every cycle unless held.
// ----------------------------------------------------------------------------
// The block accepts one 384-bit state word (twelve 32-bit lanes, three rows of
// four columns) per clock when not held and returns its ROUNDS-round Gimli
// permutation. Each round is a cell of its own that holds one state in flight,
// so up to ROUNDS words travel down the chain at once and the sustained rate
// is one word per cycle when not held. Rounds count down from ROUNDS; the
// first cell runs round ROUNDS and the last cell runs round 1, whose register
// drives the result ports directly. When the result at the end of the chain
// is stalled, the whole chain holds and in_stall rises in the same cycle; as
// soon as the result is taken, every cell advances and a new word enters.
// ----------------------------------------------------------------------------
module gimli_permutation #(
  parameter int unsigned ROUNDS = 24
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] word_0,
  input  logic [31:0] word_1,
  input  logic [31:0] word_2,
  input  logic [31:0] word_3,
  input  logic [31:0] word_4,
  input  logic [31:0] word_5,
  input  logic [31:0] word_6,
  input  logic [31:0] word_7,
  input  logic [31:0] word_8,
  input  logic [31:0] word_9,
  input  logic [31:0] word_10,
  input  logic [31:0] word_11,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_word_0,
  output logic [31:0] out_word_1,
  output logic [31:0] out_word_2,
  output logic [31:0] out_word_3,
  output logic [31:0] out_word_4,
  output logic [31:0] out_word_5,
  output logic [31:0] out_word_6,
  output logic [31:0] out_word_7,
  output logic [31:0] out_word_8,
  output logic [31:0] out_word_9,
  output logic [31:0] out_word_10,
  output logic [31:0] out_word_11
);

  // Chain taps: index 0 is the input port, index k the register of cell k.
  logic              chain_valid [ROUNDS+1];
  gimli_pkg::state_t chain_state [ROUNDS+1];
  logic [ROUNDS-1:0] stage_valid;
  logic              en;

  // Advance everything unless a finished word waits at the end.
  assign en       = !(chain_valid[ROUNDS] && out_stall);
  assign in_stall = !en;

  assign chain_valid[0] = in_valid;
  assign chain_state[0] = {word_11, word_10, word_9, word_8, word_7, word_6,
                           word_5,  word_4,  word_3, word_2, word_1, word_0};

  // One cell per round; cell k runs round ROUNDS-k+1.
  for (genvar k = 1; k <= ROUNDS; k++) begin : g_cell
    gimli_round #(
      .ROUND_NUM (ROUNDS - k + 1)
    ) u_round (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .prev_valid (chain_valid[k-1]),
      .prev_state (chain_state[k-1]),
      .valid      (chain_valid[k]),
      .state      (chain_state[k])
    );
    assign stage_valid[k-1] = chain_valid[k];
  end

  // Result comes straight from the last cell's register.
  assign out_valid   = chain_valid[ROUNDS];
  assign out_word_0  = chain_state[ROUNDS][0];
  assign out_word_1  = chain_state[ROUNDS][1];
  assign out_word_2  = chain_state[ROUNDS][2];
  assign out_word_3  = chain_state[ROUNDS][3];
  assign out_word_4  = chain_state[ROUNDS][4];
  assign out_word_5  = chain_state[ROUNDS][5];
  assign out_word_6  = chain_state[ROUNDS][6];
  assign out_word_7  = chain_state[ROUNDS][7];
  assign out_word_8  = chain_state[ROUNDS][8];
  assign out_word_9  = chain_state[ROUNDS][9];
  assign out_word_10 = chain_state[ROUNDS][10];
  assign out_word_11 = chain_state[ROUNDS][11];

`ifndef SYNTH
  // Occupancy grows by one when a word enters and none leaves.
  a_fill: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && !(out_valid && !out_stall)) |=>
      ($countones(stage_valid) == $past($countones(stage_valid)) + 1))
    else $error("chain occupancy did not grow on accept");

  // Occupancy shrinks by one when a word leaves and none enters.
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (!(in_valid && !in_stall) && out_valid && !out_stall) |=>
      ($countones(stage_valid) + 1 == $past($countones(stage_valid))))
    else $error("chain occupancy did not shrink on delivery");

  // A held chain keeps every cell's valid bit and the last cell's state.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> ($stable(stage_valid) && $stable(chain_state[ROUNDS])))
    else $error("chain moved while held");
`endif

endmodule
